FILE: design/aslim_pkg.sv
// Package for the three-axis asymmetric slew limiter.
// Holds the value, rate and step types shared by the limiter modules.
// No dependencies.
package aslim_pkg;

	localparam int AXES = 3;
	localparam int VAL_W = 32;
	localparam int RATE_W = 32;
	localparam int DT_W = 16;
	localparam int FRAC_W = 16;
	localparam int PROD_W = RATE_W + DT_W;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [RATE_W-1:0] rate_t;
	typedef logic [DT_W-1:0] dt_t;

	typedef enum logic {
		KIND_DAMP = 1'b0,
		KIND_SNAP = 1'b1
	} kind_t;

	typedef struct packed {
		rate_t rise_step;
		rate_t fall_step;
		logic  rise_zero;
		logic  fall_zero;
		logic  rates_differ;
	} step_info_t;

endpackage

FILE: design/asymmetric_slew_limiter_3axis.sv
// Top level of the three-axis asymmetric slew limiter.
// Instantiates aslim_step_mul and aslim_axis per axis; depends on aslim_pkg.
//
// Usage: a request on the input channel (in_valid/in_ready) carries the
// kind, three targets, three rise rates, three fall rates and a time step.
// Every request yields exactly one result on the output channel
// (out_valid/out_ready) with the three damped values.
// The request is captured in an input register, the rate-times-time-step
// products are formed from it and held in a second register stage, and the
// clamped update is written into the damped-value register, which is also
// the output register. One request is taken every cycle as long as the
// receiver does not stall. When it stalls, the result is held and the two
// earlier stages keep filling, so up to two further requests are taken
// before in_ready falls.
// Reset clears all damped values to zero, the mode register to zero and all
// stage valid flags. absolute_mode is written with cfg_wr_en and should only
// change while the block is idle.
module asymmetric_slew_limiter_3axis (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic             cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic [31:0]      rise_rate_x,
	input  logic [31:0]      rise_rate_y,
	input  logic [31:0]      rise_rate_z,
	input  logic [31:0]      fall_rate_x,
	input  logic [31:0]      fall_rate_y,
	input  logic [31:0]      fall_rate_z,
	input  logic [15:0]      time_step,
	output logic             out_valid,
	input  logic             out_ready,
	output logic signed [31:0] damped_x,
	output logic signed [31:0] damped_y,
	output logic signed [31:0] damped_z
);

	logic absolute_mode_q;

	logic                   valid_s1;
	aslim_pkg::kind_t       kind_s1;
	aslim_pkg::val_t        tgt_s1 [aslim_pkg::AXES];
	aslim_pkg::rate_t       rise_s1 [aslim_pkg::AXES];
	aslim_pkg::rate_t       fall_s1 [aslim_pkg::AXES];
	aslim_pkg::dt_t         dt_s1;

	logic                   valid_s2;
	aslim_pkg::kind_t       kind_s2;
	aslim_pkg::val_t        tgt_s2 [aslim_pkg::AXES];
	aslim_pkg::step_info_t  info_s2 [aslim_pkg::AXES];

	aslim_pkg::step_info_t  info_c [aslim_pkg::AXES];
	aslim_pkg::val_t        nxt_c [aslim_pkg::AXES];
	aslim_pkg::val_t        damped_q [aslim_pkg::AXES];
	logic                   out_valid_q;

	logic out_free;
	logic s2_free;
	logic s1_free;
	logic commit;

	assign out_free = !out_valid_q || out_ready;
	assign s2_free = !valid_s2 || out_free;
	assign s1_free = !valid_s1 || s2_free;
	assign commit = valid_s2 && out_free;
	assign in_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absolute_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			absolute_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_valid) begin
			kind_s1 <= aslim_pkg::kind_t'(kind);
			tgt_s1[0] <= target_x;
			tgt_s1[1] <= target_y;
			tgt_s1[2] <= target_z;
			rise_s1[0] <= rise_rate_x;
			rise_s1[1] <= rise_rate_y;
			rise_s1[2] <= rise_rate_z;
			fall_s1[0] <= fall_rate_x;
			fall_s1[1] <= fall_rate_y;
			fall_s1[2] <= fall_rate_z;
			dt_s1 <= time_step;
		end
	end

	for (genvar a = 0; a < aslim_pkg::AXES; a++) begin : g_axis
		aslim_step_mul u_mul (
			.rise_rate (rise_s1[a]),
			.fall_rate (fall_s1[a]),
			.time_step (dt_s1),
			.info      (info_c[a])
		);

		aslim_axis u_axis (
			.cur           (damped_q[a]),
			.tgt           (tgt_s2[a]),
			.info          (info_s2[a]),
			.kind          (kind_s2),
			.absolute_mode (absolute_mode_q),
			.nxt           (nxt_c[a])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			kind_s2 <= kind_s1;
			tgt_s2 <= tgt_s1;
			info_s2 <= info_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < aslim_pkg::AXES; i++) begin
				damped_q[i] <= '0;
			end
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s2;
			end
			if (commit) begin
				damped_q <= nxt_c;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign damped_x = damped_q[0];
	assign damped_y = damped_q[1];
	assign damped_z = damped_q[2];

`ifndef SYNTHESIS
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> (damped_q[0] == $past(damped_q[0])) && (damped_q[1] == $past(damped_q[1]))
			&& (damped_q[2] == $past(damped_q[2])))
		else $error("damped state changed without a committed request");

	a_snap_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (kind_s2 == aslim_pkg::KIND_SNAP)) |=>
			(damped_x == $past(tgt_s2[0])) && (damped_y == $past(tgt_s2[1]))
			&& (damped_z == $past(tgt_s2[2])))
		else $error("snap request did not load the targets");

	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> ((damped_x >= $past(damped_q[0])) && (damped_x <= $past(tgt_s2[0])))
			|| ((damped_x <= $past(damped_q[0])) && (damped_x >= $past(tgt_s2[0]))))
		else $error("axis x left the span between value and target");

	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid)
		else $error("committed request produced no result");
`endif

endmodule

FILE: design/aslim_step_mul.sv
// Per-axis step products of the slew limiter: rate times time step, scaled down.
// Also flags zero rates and unequal rise and fall rates for the next stage.
// Depends on aslim_pkg.
module aslim_step_mul (
	input  aslim_pkg::rate_t      rise_rate,
	input  aslim_pkg::rate_t      fall_rate,
	input  aslim_pkg::dt_t        time_step,
	output aslim_pkg::step_info_t info
);

	logic [aslim_pkg::PROD_W-1:0] rise_prod;
	logic [aslim_pkg::PROD_W-1:0] fall_prod;

	assign rise_prod = {{aslim_pkg::DT_W{1'b0}}, rise_rate}
		* {{aslim_pkg::RATE_W{1'b0}}, time_step};
	assign fall_prod = {{aslim_pkg::DT_W{1'b0}}, fall_rate}
		* {{aslim_pkg::RATE_W{1'b0}}, time_step};

	always_comb begin
		info.rise_step    = rise_prod[aslim_pkg::PROD_W-1:aslim_pkg::FRAC_W];
		info.fall_step    = fall_prod[aslim_pkg::PROD_W-1:aslim_pkg::FRAC_W];
		info.rise_zero    = (rise_rate == '0);
		info.fall_zero    = (fall_rate == '0);
		info.rates_differ = (rise_rate != fall_rate);
	end

endmodule

FILE: design/aslim_axis.sv
// Next-value logic for one axis of the slew limiter.
// Selects the rate, steps towards the target and clamps at it; handles snap requests.
// Depends on aslim_pkg.
module aslim_axis (
	input  aslim_pkg::val_t       cur,
	input  aslim_pkg::val_t       tgt,
	input  aslim_pkg::step_info_t info,
	input  aslim_pkg::kind_t      kind,
	input  logic                  absolute_mode,
	output aslim_pkg::val_t       nxt
);

	always_comb begin
		logic                            up;
		logic                            sel_rise;
		logic                            rate_zero;
		logic                            flips;
		aslim_pkg::rate_t                step;
		logic signed [aslim_pkg::VAL_W+1:0] cur_x;
		logic signed [aslim_pkg::VAL_W+1:0] tgt_x;
		logic signed [aslim_pkg::VAL_W+1:0] step_x;
		logic signed [aslim_pkg::VAL_W+1:0] moved;

		up = (tgt > cur);
		if (absolute_mode) begin
			sel_rise = !(((cur > 0) && !up) || ((cur < 0) && up));
		end else begin
			sel_rise = up;
		end
		rate_zero = sel_rise ? info.rise_zero : info.fall_zero;
		step = sel_rise ? info.rise_step : info.fall_step;
		flips = ((tgt < 0) && (cur > 0)) || ((tgt > 0) && (cur < 0));

		cur_x = $signed({{2{cur[aslim_pkg::VAL_W-1]}}, cur});
		tgt_x = $signed({{2{tgt[aslim_pkg::VAL_W-1]}}, tgt});
		step_x = $signed({2'b00, step});
		moved = up ? (cur_x + step_x) : (cur_x - step_x);
		if (up && (moved > tgt_x)) begin
			moved = tgt_x;
		end else if (!up && (moved < tgt_x)) begin
			moved = tgt_x;
		end

		if (kind == aslim_pkg::KIND_SNAP) begin
			nxt = tgt;
		end else if (tgt == cur) begin
			nxt = cur;
		end else if (rate_zero) begin
			nxt = (absolute_mode && flips && info.rates_differ) ? '0 : tgt;
		end else begin
			nxt = aslim_pkg::val_t'(moved[aslim_pkg::VAL_W-1:0]);
		end
	end

endmodule

FILE: sim/asymmetric_slew_limiter_3axis_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-axis asymmetric slew limiter.
// It predicts every damped triple in the bench and checks the results in order.
// Depends on aslim_pkg and asymmetric_slew_limiter_3axis.
module asymmetric_slew_limiter_3axis_tb;

	typedef aslim_pkg::val_t [aslim_pkg::AXES-1:0] val3_t;
	typedef aslim_pkg::rate_t [aslim_pkg::AXES-1:0] rate3_t;

	typedef struct packed {
		aslim_pkg::kind_t kind;
		val3_t            tgt;
		rate3_t           rise;
		rate3_t           fall;
		aslim_pkg::dt_t   dt;
	} slew_req_t;

	localparam aslim_pkg::val_t VMAX = 32'sh7FFF_FFFF;
	localparam aslim_pkg::val_t VMIN = 32'sh8000_0000;
	localparam aslim_pkg::val_t ONE = 32'sh0001_0000;
	localparam aslim_pkg::rate_t RMAX = 32'hFFFF_FFFF;
	localparam int LATENCY = 2;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	aslim_pkg::val_t target_x = '0;
	aslim_pkg::val_t target_y = '0;
	aslim_pkg::val_t target_z = '0;
	aslim_pkg::rate_t rise_rate_x = '0;
	aslim_pkg::rate_t rise_rate_y = '0;
	aslim_pkg::rate_t rise_rate_z = '0;
	aslim_pkg::rate_t fall_rate_x = '0;
	aslim_pkg::rate_t fall_rate_y = '0;
	aslim_pkg::rate_t fall_rate_z = '0;
	aslim_pkg::dt_t time_step = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	aslim_pkg::val_t damped_x;
	aslim_pkg::val_t damped_y;
	aslim_pkg::val_t damped_z;

	slew_req_t slew_req_q[$];
	val3_t damped_due_q[$];
	aslim_pkg::val_t track_pos [aslim_pkg::AXES];
	bit track_abs_mode = 1'b0;
	slew_req_t cur_req;
	val3_t want;
	logic calm = 1'b0;
	logic hold_off = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_cycles = 0;
	int ph;
	int k;

	asymmetric_slew_limiter_3axis u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.target_x    (target_x),
		.target_y    (target_y),
		.target_z    (target_z),
		.rise_rate_x (rise_rate_x),
		.rise_rate_y (rise_rate_y),
		.rise_rate_z (rise_rate_z),
		.fall_rate_x (fall_rate_x),
		.fall_rate_y (fall_rate_y),
		.fall_rate_z (fall_rate_z),
		.time_step   (time_step),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.damped_x    (damped_x),
		.damped_y    (damped_y),
		.damped_z    (damped_z)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic note_error(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic aslim_pkg::val_t slew_axis(aslim_pkg::val_t cur, aslim_pkg::val_t tgt,
		aslim_pkg::rate_t rise, aslim_pkg::rate_t fall, aslim_pkg::dt_t dt);
		logic rising;
		logic shrinking;
		logic flips;
		aslim_pkg::rate_t rate;
		logic [47:0] prod;
		longint nxt;
		if (tgt == cur)
			return cur;
		rising = tgt > cur;
		rate = rising ? rise : fall;
		if (track_abs_mode) begin
			shrinking = (cur > 0 && !rising) || (cur < 0 && rising);
			rate = shrinking ? fall : rise;
		end
		if (rate == '0) begin
			flips = (tgt > 0 && cur < 0) || (tgt < 0 && cur > 0);
			return (track_abs_mode && flips && rise != fall) ? aslim_pkg::val_t'(0) : tgt;
		end
		prod = {16'b0, rate} * {32'b0, dt};
		if (rising) begin
			nxt = longint'(cur) + longint'(prod[47:16]);
			if (nxt > longint'(tgt))
				nxt = longint'(tgt);
		end else begin
			nxt = longint'(cur) - longint'(prod[47:16]);
			if (nxt < longint'(tgt))
				nxt = longint'(tgt);
		end
		return nxt[31:0];
	endfunction

	function automatic val3_t advance_limiter(slew_req_t r);
		val3_t res;
		int i;
		for (i = 0; i < aslim_pkg::AXES; i++) begin
			if (r.kind == aslim_pkg::KIND_SNAP)
				track_pos[i] = r.tgt[i];
			else
				track_pos[i] = slew_axis(track_pos[i], r.tgt[i], r.rise[i], r.fall[i], r.dt);
			res[i] = track_pos[i];
		end
		return res;
	endfunction

	function automatic val3_t xyz(aslim_pkg::val_t x, aslim_pkg::val_t y, aslim_pkg::val_t z);
		return {z, y, x};
	endfunction

	function automatic rate3_t rxyz(aslim_pkg::rate_t x, aslim_pkg::rate_t y,
		aslim_pkg::rate_t z);
		return {z, y, x};
	endfunction

	function automatic void queue_req(aslim_pkg::kind_t kd, val3_t t, rate3_t ri, rate3_t fa,
		aslim_pkg::dt_t dt);
		slew_req_t r;
		r.kind = kd;
		r.tgt = t;
		r.rise = ri;
		r.fall = fa;
		r.dt = dt;
		slew_req_q.push_back(r);
		n_queued++;
	endfunction

	function automatic aslim_pkg::val_t rand_target();
		int v;
		v = $urandom_range(0, 2621440);
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? VMAX : VMIN;
			2: return '0;
			default: return v - 1310720;
		endcase
	endfunction

	function automatic aslim_pkg::rate_t rand_rate();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return $urandom;
			2: return RMAX;
			3: return $urandom_range(1, 255);
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	function automatic aslim_pkg::dt_t rand_dt();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'hFFFF;
			2: return aslim_pkg::dt_t'($urandom_range(1, 15));
			default: return aslim_pkg::dt_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic void queue_random();
		rate3_t ri;
		rate3_t fa;
		int i;
		for (i = 0; i < aslim_pkg::AXES; i++) begin
			ri[i] = rand_rate();
			fa[i] = ($urandom_range(0, 5) == 0) ? ri[i] : rand_rate();
		end
		queue_req(($urandom_range(0, 9) == 0) ? aslim_pkg::KIND_SNAP : aslim_pkg::KIND_DAMP,
			xyz(rand_target(), rand_target(), rand_target()), ri, fa, rand_dt());
	endfunction

	function automatic int draw_wait();
		if (calm)
			return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
	endfunction

	task automatic settle();
		while (n_checked < n_queued)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_mode(bit m);
		settle();
		@(posedge clk);
		cfg_wr_data <= m;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		track_abs_mode = m;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
			for (k = 0; k < aslim_pkg::AXES; k++)
				track_pos[k] = '0;
		end else begin
			if (in_valid && in_ready) begin
				damped_due_q.push_back(advance_limiter(cur_req));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait = send_wait - 1;
					in_valid <= 1'b0;
				end else if (slew_req_q.size() > 0) begin
					cur_req = slew_req_q.pop_front();
					kind <= cur_req.kind;
					target_x <= cur_req.tgt[0];
					target_y <= cur_req.tgt[1];
					target_z <= cur_req.tgt[2];
					rise_rate_x <= cur_req.rise[0];
					rise_rate_y <= cur_req.rise[1];
					rise_rate_z <= cur_req.rise[2];
					fall_rate_x <= cur_req.fall[0];
					fall_rate_y <= cur_req.fall[1];
					fall_rate_z <= cur_req.fall[2];
					time_step <= cur_req.dt;
					in_valid <= 1'b1;
					send_wait = draw_wait();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (damped_due_q.size() == 0) begin
					note_error("result with no request outstanding");
				end else begin
					want = damped_due_q.pop_front();
					if (damped_x !== want[0])
						note_error($sformatf("damped_x got %h expected %h", damped_x, want[0]));
					if (damped_y !== want[1])
						note_error($sformatf("damped_y got %h expected %h", damped_y, want[1]));
					if (damped_z !== want[2])
						note_error($sformatf("damped_z got %h expected %h", damped_z, want[2]));
				end
				recv_wait = draw_wait();
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait = recv_wait - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// The receiver stops for a long stretch so that the pipeline fills and refuses requests.
	initial begin
		while (n_accepted < 60)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMAX, VMIN, ONE), rxyz(RMAX, RMAX, RMAX),
			rxyz(RMAX, RMAX, RMAX), 16'hFFFF);
		queue_req(aslim_pkg::KIND_SNAP, xyz(VMIN, VMAX, 0), rxyz($urandom, $urandom, $urandom),
			rxyz($urandom, $urandom, $urandom), aslim_pkg::dt_t'($urandom));
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMAX, VMIN, 5 * ONE), rxyz(1, 1, 1), rxyz(1, 1, 1),
			16'd1);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMIN, VMAX, 0), rxyz(0, 0, 0), rxyz(0, 0, 0),
			16'hFFFF);
		queue_req(aslim_pkg::KIND_DAMP, xyz(0, 0, ONE), rxyz(ONE, ONE, ONE),
			rxyz(ONE, ONE, ONE), 16'd0);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMAX, VMIN, -ONE), rxyz(0, 0, 0), rxyz(0, 0, 0),
			16'h1234);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMIN, VMAX, 3 * ONE), rxyz(RMAX, RMAX, RMAX),
			rxyz(RMAX, RMAX, RMAX), 16'hFFFF);
		queue_req(aslim_pkg::KIND_DAMP, xyz(-5 * ONE, 5 * ONE, 0), rxyz(ONE, ONE, ONE),
			rxyz(2 * ONE, 2 * ONE, 2 * ONE), 16'h8000);
		queue_req(aslim_pkg::KIND_DAMP, xyz(-5 * ONE, 5 * ONE, 0), rxyz(ONE, ONE, ONE),
			rxyz(2 * ONE, 2 * ONE, 2 * ONE), 16'h8000);
		queue_req(aslim_pkg::KIND_SNAP, xyz(ONE, -ONE, 0), rxyz(RMAX, RMAX, RMAX),
			rxyz(RMAX, RMAX, RMAX), 16'hFFFF);

		set_mode(1'b1);
		queue_req(aslim_pkg::KIND_DAMP, xyz(-2 * ONE, 2 * ONE, 3 * ONE), rxyz(7, 3, 0),
			rxyz(0, 0, 9), 16'h1000);
		queue_req(aslim_pkg::KIND_SNAP, xyz(ONE, -ONE, 5), rxyz(0, 0, 0), rxyz(0, 0, 0),
			16'h0);
		queue_req(aslim_pkg::KIND_DAMP, xyz(-2 * ONE, 2 * ONE, -10), rxyz(0, 0, 0),
			rxyz(0, 0, 0), 16'h4000);
		queue_req(aslim_pkg::KIND_SNAP, xyz(-3 * ONE, 3 * ONE, 0), rxyz(0, 0, 0),
			rxyz(0, 0, 0), 16'h0);
		queue_req(aslim_pkg::KIND_DAMP, xyz(-10 * ONE, 10 * ONE, -ONE), rxyz(ONE, ONE, ONE),
			rxyz(4 * ONE, 4 * ONE, 4 * ONE), 16'h8000);
		queue_req(aslim_pkg::KIND_DAMP, xyz(0, 0, ONE), rxyz(ONE, ONE, ONE),
			rxyz(4 * ONE, 4 * ONE, 4 * ONE), 16'h8000);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMAX, VMIN, VMIN), rxyz(0, 0, 0),
			rxyz(5, 5, 4 * ONE), 16'h8000);
		queue_req(aslim_pkg::KIND_DAMP, xyz(VMIN, VMAX, VMAX), rxyz(0, 0, 0), rxyz(0, 0, 0),
			16'hFFFF);

		for (ph = 0; ph < 3; ph++) begin
			set_mode(ph != 1);
			calm <= (ph == 2);
			repeat (145) queue_random();
		end

		settle();
		repeat (10) @(posedge clk);
		if (damped_due_q.size() != 0)
			note_error($sformatf("%0d results never arrived", damped_due_q.size()));
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
